### sv/note_lane_allocator_unit_defines.svh
// Assertion macros for the note lane allocator
`ifndef NOTE_LANE_ALLOCATOR_UNIT_DEFINES_SVH
`define NOTE_LANE_ALLOCATOR_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define NLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define NLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/nla_pkg.sv
// Shared types and constants for the note lane allocator
package nla_pkg;
	localparam int LANES     = 16;
	localparam int TICK_BITS = 24;
	localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CNT_BITS  = $clog2(LANES + 1);

	typedef logic [TICK_BITS-1:0] tick_t;

	// player state of one lane
	typedef struct packed {
		logic signed [8:0] instr;
		logic signed [7:0] octave;
		logic signed [8:0] dyn;
		logic signed [8:0] pan;
		logic signed [1:0] reverb;
	} pstate_t;

	typedef struct packed {
		tick_t   busy;
		pstate_t st;
	} lane_rec_t;

	localparam pstate_t UNSET = '{instr: '1, octave: '1, dyn: '1, pan: '1, reverb: '1};

	// control from the sequencer to the cell row
	typedef struct packed {
		logic    rotate;
		logic    write;
		pstate_t wr_st;
		tick_t   wr_busy;
		logic    reset_rec;
	} row_ctl_t;

	// required fields compared against one lane; mask and byte cost
	function automatic logic [4:0] diff_mask(pstate_t need, pstate_t have);
		logic [4:0] m;
		m[0] = !need.instr[8]  && need.instr  != have.instr;
		m[1] = !need.octave[7] && need.octave != have.octave;
		m[2] = !need.dyn[8]    && need.dyn    != have.dyn;
		m[3] = !need.pan[8]    && need.pan    != have.pan;
		m[4] = !need.reverb[1] && need.reverb != have.reverb;
		return m;
	endfunction

	function automatic logic [3:0] mask_cost(logic [4:0] m);
		return {3'b0, m[0]} + {3'b0, m[1]} + {3'b0, m[2]} + {3'b0, m[3]}
			+ {3'b0, m[0]} + {3'b0, m[1]} + {3'b0, m[2]} + {3'b0, m[3]}
			+ {3'b0, m[4]};
	endfunction
endpackage

### sv/note_lane_allocator_unit.sv
// Top level of the note lane allocator: sequencer, running totals, result port
//
//  channel  | handshake          | payload
//  cfg      | cfg_valid/ready    | cfg_data (lane_limit)
//  request  | start & !busy      | onset_tick .. need_reverb
//  result   | done strobe        | lane .. lanes_in_use
//
// A request passes the lanes through the head cell twice (one pass to score,
// one to write back the chosen lane), between a load and a result state. A
// refused request after failure goes straight to the refuse and result states.
// Reset clears every lane record at once. Results cannot be stalled.
module note_lane_allocator_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [4:0]               cfg_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [nla_pkg::TICK_BITS-1:0] onset_tick,
	input  logic [nla_pkg::TICK_BITS-1:0] stop_tick,
	input  logic signed [8:0]        need_instrument,
	input  logic signed [7:0]        need_octave,
	input  logic signed [8:0]        need_dynamics,
	input  logic signed [8:0]        need_pan,
	input  logic signed [1:0]        need_reverb,
	output logic                     done,
	output logic [3:0]               lane,
	output logic                     opened_new,
	output logic [nla_pkg::TICK_BITS-1:0] rest_ticks,
	output logic [4:0]               change_mask,
	output logic [3:0]               change_bytes,
	output logic                     failed,
	output logic [31:0]              total_change_bytes,
	output logic [23:0]              zero_cost_count,
	output logic [4:0]               lanes_in_use
);
	import nla_pkg::*;
	`include "note_lane_allocator_unit_defines.svh"

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_REFUSE, S_DONE} state_t;

	state_t             state_q;
	logic [4:0]         limit_q;
	logic [LANE_BITS:0] step_q;
	tick_t              start_q, end_q;
	pstate_t            need_q;
	logic               found_q, opened_q;
	logic [LANE_BITS-1:0] best_q;
	logic [3:0]         low_cost_q;
	logic [CNT_BITS-1:0] open_q;
	logic               fail_q;
	logic [31:0]        total_q;
	logic [23:0]        zc_q;
	logic [4:0]         mask_q;
	logic [3:0]         cost_q;
	tick_t              rest_q;
	logic [LANE_BITS-1:0] lane_q;

	row_ctl_t  ctl;
	lane_rec_t head;
	logic [LANE_BITS-1:0] head_idx;
	logic [4:0] hmask;
	logic [3:0] hcost;
	logic       hfree;
	logic [CNT_BITS-1:0] cap;
	pstate_t    new_st;

	assign head_idx = step_q[LANE_BITS-1:0];
	assign hmask = diff_mask(need_q, head.st);
	assign hcost = mask_cost(hmask);
	assign hfree = (head.busy <= start_q) && ({1'b0, head_idx} < (LANE_BITS+1)'(open_q));
	assign cap = ({1'b0, limit_q} > 6'(LANES)) ? CNT_BITS'(LANES) : CNT_BITS'(limit_q);

	// merge the required fields into the chosen lane's state
	always_comb begin
		new_st = head.st;
		if (hmask[0]) new_st.instr  = need_q.instr;
		if (hmask[1]) new_st.octave = need_q.octave;
		if (hmask[2]) new_st.dyn    = need_q.dyn;
		if (hmask[3]) new_st.pan    = need_q.pan;
		if (hmask[4]) new_st.reverb = (need_q.reverb != 2'sd0) ? 2'sd1 : 2'sd0;
	end

	always_comb begin
		ctl = '0;
		ctl.rotate  = (state_q == S_SCAN) || (state_q == S_WRITE);
		ctl.write   = (state_q == S_WRITE) && found_q && (head_idx == best_q);
		ctl.wr_st   = new_st;
		ctl.wr_busy = end_q;
	end

	nla_row u_row (.clk(clk), .arst_n(arst_n), .ctl(ctl), .head_rec(head));

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			start_q <= '0;
			end_q <= '0;
			need_q <= '0;
			found_q <= 1'b0;
			opened_q <= 1'b0;
			best_q <= '0;
			low_cost_q <= '0;
			open_q <= '0;
			fail_q <= 1'b0;
			total_q <= '0;
			zc_q <= '0;
			done <= 1'b0;
			mask_q <= '0;
			cost_q <= '0;
			rest_q <= '0;
			lane_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						start_q <= onset_tick;
						end_q <= stop_tick;
						need_q <= '{instr: need_instrument, octave: need_octave,
							dyn: need_dynamics, pan: need_pan, reverb: need_reverb};
						step_q <= '0;
						found_q <= 1'b0;
						opened_q <= 1'b0;
						low_cost_q <= 4'hF;
						state_q <= fail_q ? S_REFUSE : S_SCAN;
					end
				end
				S_SCAN: begin
					// score the head lane; ties keep the lower index
					if (hfree && (!found_q || hcost < low_cost_q) &&
						!(found_q && low_cost_q == 4'd0)) begin
						found_q <= 1'b1;
						best_q <= head_idx;
						low_cost_q <= hcost;
					end
					step_q <= step_q + 1'b1;
					if (step_q == (LANE_BITS+1)'(LANES - 1)) begin
						step_q <= '0;
						if (!(found_q || (hfree && !(found_q && low_cost_q == 4'd0)))) begin
							if (open_q < cap) begin
								found_q <= 1'b1;
								opened_q <= 1'b1;
								best_q <= open_q[LANE_BITS-1:0];
								open_q <= open_q + 1'b1;
								state_q <= S_WRITE;
							end else begin
								fail_q <= 1'b1;
								state_q <= S_REFUSE;
							end
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					// write back at the chosen lane as it passes the head
					if (head_idx == best_q) begin
						mask_q <= hmask;
						cost_q <= hcost;
						lane_q <= head_idx;
						rest_q <= (start_q > head.busy) ? start_q - head.busy : '0;
						total_q <= (total_q > 32'hFFFF_FFFF - {28'd0, hcost}) ?
							32'hFFFF_FFFF : total_q + {28'd0, hcost};
						if (hcost == 4'd0 && zc_q != 24'hFF_FFFF)
							zc_q <= zc_q + 1'b1;
					end
					step_q <= step_q + 1'b1;
					if (step_q == (LANE_BITS+1)'(LANES - 1)) begin
						step_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_REFUSE: begin
					mask_q <= '0;
					cost_q <= '0;
					lane_q <= '0;
					rest_q <= '0;
					opened_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign lane = 4'(lane_q);
	assign opened_new = opened_q;
	assign rest_ticks = rest_q;
	assign change_mask = mask_q;
	assign change_bytes = cost_q;
	assign failed = fail_q;
	assign total_change_bytes = total_q;
	assign zero_cost_count = zc_q;
	assign lanes_in_use = 5'(open_q);

	`NLA_ASSERT_IMP(a_fail_clean, clk, arst_n, done && failed, change_bytes == 4'd0 && change_mask == 5'd0, "failed result carries changes")
	`NLA_ASSERT_NEXT(a_fail_sticky, clk, arst_n, failed, failed, "failure flag dropped")
	`NLA_ASSERT_IMP(a_open_cap, clk, arst_n, 1'b1, open_q <= CNT_BITS'(LANES), "too many lanes open")
	`NLA_ASSERT_IMP(a_done_busy, clk, arst_n, done, !busy, "result while busy")
endmodule

### sv/nla_cell.sv
// One lane cell: holds a lane record and passes it to its neighbour on rotate
module nla_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  nla_pkg::row_ctl_t ctl,
	input  nla_pkg::lane_rec_t rec_in,
	input  logic              head,
	output nla_pkg::lane_rec_t rec
);
	import nla_pkg::*;

	lane_rec_t rec_q;

	// hold, take the neighbour's record, or take the update at the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '{busy: '0, st: UNSET};
		end else if (ctl.reset_rec) begin
			rec_q <= '{busy: '0, st: UNSET};
		end else if (ctl.rotate) begin
			if (head && ctl.write)
				rec_q <= '{busy: ctl.wr_busy, st: ctl.wr_st};
			else
				rec_q <= rec_in;
		end
	end

	assign rec = rec_q;
endmodule

### sv/nla_row.sv
// Ring of lane cells; cell 0 is the head that the scanner inspects
module nla_row (
	input  logic               clk,
	input  logic               arst_n,
	input  nla_pkg::row_ctl_t  ctl,
	output nla_pkg::lane_rec_t head_rec
);
	import nla_pkg::*;

	lane_rec_t recs [LANES];

	// cell i takes from cell i+1; the last cell takes the (possibly updated) head
	for (genvar i = 0; i < LANES; i++) begin : g_cell
		nla_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.rec_in (recs[(i + 1) % LANES]),
			.head   (i == LANES - 1),
			.rec    (recs[i])
		);
	end

	assign head_rec = recs[0];
endmodule
